FILE: hw/rtl/dar_pkg.sv
package dar_pkg;

  localparam int MAX_RADIUS_DEF = 31;
  localparam int MASK_W         = 63;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CANVAS_WIDTH   = 3'd0,
    REG_CANVAS_HEIGHT  = 3'd1,
    REG_RING_MODE      = 3'd2,
    REG_RING_THICKNESS = 3'd3,
    REG_PEN_COLOR      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [12:0] canvas_width;
    logic [12:0] canvas_height;
    logic        ring_mode;
    logic [4:0]  ring_thickness;
    logic [31:0] pen_color;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

FILE: hw/rtl/dar_cfg_regs.sv
module dar_cfg_regs
  import dar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width   <= 13'd1600;
      cfg.canvas_height  <= 13'd900;
      cfg.ring_mode      <= 1'b0;
      cfg.ring_thickness <= 5'd0;
      cfg.pen_color      <= 32'hFF00_0000;
    end else if (cfg_write) begin
      // Indexes past the register list are ignored.
      unique case (cfg_index)
        REG_CANVAS_WIDTH:   cfg.canvas_width   <= cfg_data[12:0];
        REG_CANVAS_HEIGHT:  cfg.canvas_height  <= cfg_data[12:0];
        REG_RING_MODE:      cfg.ring_mode      <= cfg_data[0];
        REG_RING_THICKNESS: cfg.ring_thickness <= cfg_data[4:0];
        REG_PEN_COLOR:      cfg.pen_color      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/dar_ctrl.sv
module dar_ctrl
  import dar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  // A row is produced whenever the output register is empty or being drained.
  assign cmd.emit = (state == S_RUN) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_RUN;
      S_RUN:  if (cmd.emit && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hw/rtl/dar_datapath.sv
module dar_datapath
  import dar_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic               clk,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  cfg_t               cfg,
  input  logic [11:0]        center_x,
  input  logic [11:0]        center_y,
  input  logic [4:0]         radius,
  output logic signed [13:0] row_y,
  output logic signed [12:0] left_x,
  output logic [MASK_W-1:0]  coverage_mask,
  output logic [31:0]        pixel_color,
  output logic               last_row
);

  localparam int LANES = 2 * MAX_RADIUS + 1;
  localparam logic [4:0] R_MAX = 5'(MAX_RADIUS);

  // Per-command values captured at accept.
  logic [11:0]        cy_q;
  logic [4:0]         r_q;
  logic [9:0]         r2_q;
  logic [9:0]         inner2_q;
  logic signed [12:0] left_q;
  logic [5:0]         k_q;

  logic [4:0]        r_sat;
  logic signed [6:0] inner;
  logic [4:0]        inner_abs;

  assign r_sat     = (radius > R_MAX) ? R_MAX : radius;
  assign inner     = $signed({2'b00, r_sat}) - $signed({2'b00, cfg.ring_thickness});
  // Both operands are at most 31, so the magnitude fits in five bits.
  assign inner_abs = inner[6] ? 5'(-inner) : inner[4:0];

  // Row offset and its square.
  logic signed [6:0]  dy;
  logic [5:0]         dy_abs;
  logic [11:0]        dy2;
  logic signed [13:0] y;
  logic               row_on;

  assign dy     = $signed({1'b0, k_q}) - $signed({2'b00, r_q});
  assign dy_abs = dy[6] ? 6'(-dy) : dy[5:0];
  assign dy2    = {6'd0, dy_abs} * {6'd0, dy_abs};
  assign y      = $signed({2'b00, cy_q}) + 14'(dy);
  assign row_on = !y[13] && (y[12:0] < cfg.canvas_height);

  logic [MASK_W-1:0] mask_row;

  genvar j;
  generate
    for (j = 0; j < MASK_W; j++) begin : g_lane
      if (j < LANES) begin : g_on
        logic signed [6:0]  dx;
        logic [5:0]         dx_abs;
        logic [11:0]        dx2;
        logic [12:0]        d2;
        logic signed [13:0] x;
        logic               hit;
        logic               col_on;

        assign dx     = $signed(7'(j)) - $signed({2'b00, r_q});
        assign dx_abs = dx[6] ? 6'(-dx) : dx[5:0];
        assign dx2    = {6'd0, dx_abs} * {6'd0, dx_abs};
        assign d2     = {1'b0, dx2} + {1'b0, dy2};
        assign hit    = (d2 <= {3'd0, r2_q}) &&
                        !(cfg.ring_mode && (d2 < {3'd0, inner2_q}));
        assign x      = 14'(left_q) + $signed(14'(j));
        assign col_on = !x[13] && (x[12:0] < cfg.canvas_width);
        assign mask_row[j] = row_on && hit && col_on;
      end else begin : g_off
        assign mask_row[j] = 1'b0;
      end
    end
  endgenerate

  assign status.last = (k_q == {r_q, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cy_q     <= center_y;
      r_q      <= r_sat;
      r2_q     <= {5'd0, r_sat} * {5'd0, r_sat};
      inner2_q <= {5'd0, inner_abs} * {5'd0, inner_abs};
      left_q   <= $signed({1'b0, center_x}) - $signed({8'd0, r_sat});
      k_q      <= '0;
    end else if (cmd.emit) begin
      k_q <= k_q + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_y         <= y;
      left_x        <= left_q;
      coverage_mask <= mask_row;
      pixel_color   <= cfg.pen_color;
      last_row      <= status.last;
    end
  end

endmodule

FILE: hw/rtl/disk_and_ring_rasterizer_core.sv
// Disk and ring rasterizer. Each accepted command (center and radius, the
// radius saturated at MAX_RADIUS) yields 2r+1 row items from the top of the
// bounding box down, each with a 63-bit coverage mask whose bit 0 sits at
// center_x - r. The row sequencer produces one row per cycle; a stall on
// the output holds the sequencer. The next command is taken once the final
// row sits in the output register. The ring thickness is captured when a
// command is accepted and the other configuration registers are sampled
// live, so configuration must only be written while no command is in
// progress.
module disk_and_ring_rasterizer_core
  import dar_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [11:0]            center_x,
  input  logic [11:0]            center_y,
  input  logic [4:0]             radius,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [13:0]     row_y,
  output logic signed [12:0]     left_x,
  output logic [MASK_W-1:0]      coverage_mask,
  output logic [31:0]            pixel_color,
  output logic                   last_row
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  dar_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dar_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .row_y         (row_y),
    .left_x        (left_x),
    .coverage_mask (coverage_mask),
    .pixel_color   (pixel_color),
    .last_row      (last_row)
  );

endmodule
